>>> sv/bptc_pkg.sv
// Shared types, constants and arithmetic helpers for the barometric
// temperature and pressure compensation pipeline. No dependencies.
package bptc_pkg;

  // fine temperature always lies well inside +-2^25
  localparam int unsigned FINE_W     = 26;
  // divisor magnitude width (divisor is a 64-bit value shifted right by 33)
  localparam int unsigned DIV_W      = 31;
  // one quotient bit per divider stage
  localparam int unsigned DIV_STAGES = 64;

  localparam logic signed [27:0] FINE_OFFSET = 28'sd128000;
  localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
  localparam logic signed [16:0] PRESS_SCALE = 17'sd3125;
  localparam logic [63:0]        VAR1_BIAS   = 64'd1 << 47;
  localparam logic [63:0]        PRESS_MAX   = 64'd16777215;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP_COEFFS  = 2'd0,
    CFG_PRESS_LOW    = 2'd1,
    CFG_PRESS_HIGH   = 2'd2,
    CFG_PRESS_NINE   = 2'd3
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [23:0] temp_centi;
    logic [23:0]        press_pa;
    logic               press_invalid;
  } out_t;

  // unpacked calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  // per-item sideband that rides along the pipeline
  typedef struct packed {
    logic               inv;
    logic signed [23:0] tc;
  } side_t;

  // arithmetic shift right of a 64-bit two's complement word
  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] xs;
    xs = $signed(x);
    return 64'(xs >>> n);
  endfunction

  // low 64 bits of x times a signed 17-bit factor, as two narrow partial products
  function automatic logic [63:0] mul64x17(input logic [63:0] x,
                                           input logic signed [16:0] y);
    logic signed [49:0] lo;
    logic signed [49:0] hi;
    lo = $signed({1'b0, x[31:0]}) * y;
    hi = $signed({1'b0, x[63:32]}) * y;
    return {{14{lo[49]}}, lo} + {hi[31:0], 32'd0};
  endfunction

  // 16-bit signed coefficient widened to 17 bits
  function automatic logic signed [16:0] sx17(input logic [15:0] c);
    return $signed({c[15], c});
  endfunction

endpackage

>>> sv/baro_temp_pressure_compensation.sv
// Top level of the barometric compensation pipeline: calibration registers
// and the four pipeline sections. Depends on bptc_pkg and the bptc_* modules.
//
// Usage:
//   Input channel: present a raw temperature / pressure pair on item_i and
//   raise start for one cycle; the beat is taken at that edge whenever busy
//   is low. busy never rises: the pipeline takes a new beat every cycle.
//   Result channel: result_valid_o is high for exactly one cycle with the
//   matching res_o; results come out in input order, after the accepting
//   edge through 3 temperature, 6 pressure setup and 64 divider stages of
//   one quotient bit each, then 5 refinement and output stages.
//   Throughput is one beat per cycle, set by the 64-stage divider pipeline.
//   The receiver has no way to stall; every result must be captured in its
//   strobe cycle.
//   Calibration: write cfg_data_i to register cfg_idx_i when cfg_we_i is
//   high; write only while no beat is in flight.
//   Reset clears the calibration registers and all pipeline valid bits;
//   beats in flight are dropped.
module baro_temp_pressure_compensation import bptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         item_i,
  output logic        result_valid_o,
  output out_t        res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [47:0] temp_coeffs_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_nine_q;
  coef_t       coef;

  logic                     t_vld, v_vld, d_vld;
  side_t                    t_side, v_side, d_side;
  logic signed [FINE_W-1:0] fine;
  logic [19:0]              raw_press;
  logic [63:0]              ma, quo;
  logic [DIV_W-1:0]         md;
  logic                     v_neg, d_neg;

  assign busy = 1'b0;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_low_q   <= '0;
      press_high_q  <= '0;
      press_nine_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP_COEFFS: temp_coeffs_q <= cfg_data_i[47:0];
        CFG_PRESS_LOW:   press_low_q   <= cfg_data_i;
        CFG_PRESS_HIGH:  press_high_q  <= cfg_data_i;
        CFG_PRESS_NINE:  press_nine_q  <= cfg_data_i[15:0];
      endcase
    end
  end

  // coefficient unpacking
  always_comb begin
    coef.t1 = temp_coeffs_q[15:0];
    coef.t2 = temp_coeffs_q[31:16];
    coef.t3 = temp_coeffs_q[47:32];
    coef.p1 = press_low_q[15:0];
    coef.p2 = press_low_q[31:16];
    coef.p3 = press_low_q[47:32];
    coef.p4 = press_low_q[63:48];
    coef.p5 = press_high_q[15:0];
    coef.p6 = press_high_q[31:16];
    coef.p7 = press_high_q[47:32];
    coef.p8 = press_high_q[63:48];
    coef.p9 = press_nine_q;
  end

  bptc_temp u_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (start && !busy),
    .item_i      (item_i),
    .coef_i      (coef),
    .vld_o       (t_vld),
    .side_o      (t_side),
    .fine_o      (fine),
    .raw_press_o (raw_press)
  );

  bptc_pvar u_pvar (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (t_vld),
    .side_i      (t_side),
    .fine_i      (fine),
    .raw_press_i (raw_press),
    .coef_i      (coef),
    .vld_o       (v_vld),
    .side_o      (v_side),
    .ma_o        (ma),
    .md_o        (md),
    .neg_o       (v_neg)
  );

  bptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v_vld),
    .side_i (v_side),
    .ma_i   (ma),
    .md_i   (md),
    .neg_i  (v_neg),
    .vld_o  (d_vld),
    .side_o (d_side),
    .quo_o  (quo),
    .neg_o  (d_neg)
  );

  bptc_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d_vld),
    .side_i (d_side),
    .quo_i  (quo),
    .neg_i  (d_neg),
    .coef_i (coef),
    .vld_o  (result_valid_o),
    .res_o  (res_o)
  );

  // a zero divisor forces a zero pressure
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.press_invalid) |-> (res_o.press_pa == '0))
    else $error("invalid pressure beat carries a nonzero value");

  // the temperature stage never flags a beat as invalid
  a_temp_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_vld |-> !t_side.inv)
    else $error("temperature stage raised the invalid flag");

  // one beat per cycle: the pipeline never pushes back
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("start refused");

endmodule

>>> sv/bptc_temp.sv
// Fine temperature and centi-degree temperature, three register stages.
// Depends on bptc_pkg.
module bptc_temp import bptc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  in_t                      item_i,
  input  coef_t                    coef_i,
  output logic                     vld_o,
  output side_t                    side_o,
  output logic signed [FINE_W-1:0] fine_o,
  output logic [19:0]              raw_press_o
);

  logic [2:0]         vld_q, vld_d;
  logic [19:0]        rp_q [3];

  logic signed [19:0] ta;
  logic signed [18:0] tb;
  logic signed [35:0] pa_d, pa_q;
  logic signed [37:0] sq_d, sq_q;

  logic signed [24:0] a_d, a_q;
  logic signed [25:0] sqs;
  logic signed [41:0] pb_d, pb_q;

  logic signed [FINE_W-1:0] fine_d, fine_q;
  logic signed [29:0]       m;
  logic signed [21:0]       sh;
  side_t                    side_d, side_q;

  // stage 1: the two first products
  always_comb begin
    ta   = $signed({3'b0, item_i.raw_temp[19:3]}) - $signed({3'b0, coef_i.t1, 1'b0});
    tb   = $signed({3'b0, item_i.raw_temp[19:4]}) - $signed({3'b0, coef_i.t1});
    pa_d = ta * $signed(coef_i.t2);
    sq_d = tb * tb;
  end

  // stage 2: scale and multiply by t3
  always_comb begin
    a_d  = 25'(pa_q >>> 11);
    sqs  = 26'(sq_q >>> 12);
    pb_d = sqs * $signed(coef_i.t3);
  end

  // stage 3: fine temperature and rounding to 0.01 degC
  // the 22-bit quotient always fits the 24-bit output, so no clamp is needed
  always_comb begin
    fine_d     = FINE_W'(a_q) + FINE_W'(pb_q >>> 14);
    m          = (30'(fine_d) * 30'sd5) + 30'sd128;
    sh         = 22'(m >>> 8);
    side_d.inv = 1'b0;
    side_d.tc  = 24'(sh);
  end

  // valid bits
  assign vld_d = {vld_q[1:0], vld_i};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pa_q   <= pa_d;
    sq_q   <= sq_d;
    a_q    <= a_d;
    pb_q   <= pb_d;
    fine_q <= fine_d;
    side_q <= side_d;
    rp_q[0] <= item_i.raw_press;
    rp_q[1] <= rp_q[0];
    rp_q[2] <= rp_q[1];
  end

  assign vld_o       = vld_q[2];
  assign side_o      = side_q;
  assign fine_o      = fine_q;
  assign raw_press_o = rp_q[2];

endmodule

>>> sv/bptc_pvar.sv
// Pressure numerator and divisor, six register stages, ending in sign and
// magnitude for the divider. Depends on bptc_pkg.
module bptc_pvar import bptc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  side_t                    side_i,
  input  logic signed [FINE_W-1:0] fine_i,
  input  logic [19:0]              raw_press_i,
  input  coef_t                    coef_i,
  output logic                     vld_o,
  output side_t                    side_o,
  output logic [63:0]              ma_o,
  output logic [DIV_W-1:0]         md_o,
  output logic                     neg_o
);

  logic [5:0]  vld_q, vld_d;
  side_t       side_q [6];

  // stage 4
  logic signed [27:0] av;
  logic signed [55:0] aa_d, aa_q;
  logic signed [43:0] ap5_d, ap5_q, ap2_d, ap2_q;
  logic [20:0]        p21_d, p21_q [3];
  // stage 5
  logic [63:0]        b6_d, b6_q, a3_d, a3_q;
  logic signed [43:0] ap5_q2, ap2_q2;
  // stage 6
  logic [63:0]        b_d, b_q, var1_d, var1_q;
  // stage 7
  logic [63:0]        v_d, v_q, num0_d, num0_q;
  // stage 8
  logic [DIV_W-1:0]   dv_d, dv_q;
  logic [63:0]        num_d, num_q;
  // stage 9
  logic [63:0]        ma_d, ma_q;
  logic [DIV_W-1:0]   md_d, md_q;
  logic               neg_d, neg_q;
  logic               inv;

  // stage 4: offset fine temperature and its products, offset raw pressure
  always_comb begin
    av    = 28'(fine_i) - FINE_OFFSET;
    aa_d  = av * av;
    ap5_d = av * $signed(coef_i.p5);
    ap2_d = av * $signed(coef_i.p2);
    p21_d = PRESS_BASE - {1'b0, raw_press_i};
  end

  // stage 5: square times p6 and p3, wrapping to 64 bits
  always_comb begin
    b6_d = mul64x17({{8{aa_q[55]}}, aa_q}, sx17(coef_i.p6));
    a3_d = mul64x17({{8{aa_q[55]}}, aa_q}, sx17(coef_i.p3));
  end

  // stage 6: sum the numerator offset and the first divisor term
  always_comb begin
    b_d    = b6_q + ({{20{ap5_q2[43]}}, ap5_q2} << 17)
           + ({{48{coef_i.p4[15]}}, coef_i.p4} << 35);
    var1_d = VAR1_BIAS + asr64(a3_q, 8) + ({{20{ap2_q2[43]}}, ap2_q2} << 12);
  end

  // stage 7: scale divisor by p1, form raw numerator
  always_comb begin
    v_d    = mul64x17(var1_q, $signed({1'b0, coef_i.p1}));
    num0_d = ({43'd0, p21_q[2]} << 31) - b_q;
  end

  // stage 8: final divisor and scaled numerator
  always_comb begin
    dv_d  = v_q[63:33];
    num_d = mul64x17(num0_q, PRESS_SCALE);
  end

  // stage 9: sign and magnitude split, zero divisor flag
  always_comb begin
    inv   = (dv_q == '0);
    ma_d  = num_q[63] ? (64'd0 - num_q) : num_q;
    md_d  = dv_q[DIV_W-1] ? (DIV_W'(0) - dv_q) : dv_q;
    neg_d = num_q[63] ^ dv_q[DIV_W-1];
  end

  // valid bits
  assign vld_d = {vld_q[4:0], vld_i};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    aa_q     <= aa_d;
    ap5_q    <= ap5_d;
    ap2_q    <= ap2_d;
    p21_q[0] <= p21_d;
    b6_q     <= b6_d;
    a3_q     <= a3_d;
    ap5_q2   <= ap5_q;
    ap2_q2   <= ap2_q;
    p21_q[1] <= p21_q[0];
    b_q      <= b_d;
    var1_q   <= var1_d;
    p21_q[2] <= p21_q[1];
    v_q      <= v_d;
    num0_q   <= num0_d;
    dv_q     <= dv_d;
    num_q    <= num_d;
    ma_q     <= ma_d;
    md_q     <= md_d;
    neg_q    <= neg_d;
    side_q[0] <= side_i;
    for (int i = 1; i < 5; i++) begin
      side_q[i] <= side_q[i-1];
    end
    side_q[5] <= '{inv: inv, tc: side_q[4].tc};
  end

  assign vld_o  = vld_q[5];
  assign side_o = side_q[5];
  assign ma_o   = ma_q;
  assign md_o   = md_q;
  assign neg_o  = neg_q;

endmodule

>>> sv/bptc_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on bptc_pkg.
module bptc_div import bptc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  side_t            side_i,
  input  logic [63:0]      ma_i,
  input  logic [DIV_W-1:0] md_i,
  input  logic             neg_i,
  output logic             vld_o,
  output side_t            side_o,
  output logic [63:0]      quo_o,
  output logic             neg_o
);

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic             vld_q  [DIV_STAGES];
  side_t            side_q [DIV_STAGES];
  logic [DIV_W-1:0] rem_q  [DIV_STAGES];
  logic [63:0]      quo_q  [DIV_STAGES];
  logic [DIV_W-1:0] md_q   [DIV_STAGES];
  logic             neg_q  [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic             vld_in;
    side_t            side_in;
    logic [DIV_W-1:0] rem_in, md_in;
    logic [63:0]      quo_in;
    logic             neg_in;
    logic [DIV_W:0]   trial, diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = side_i;
      assign rem_in  = '0;
      assign quo_in  = ma_i;
      assign md_in   = md_i;
      assign neg_in  = neg_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign md_in   = md_q[g-1];
      assign neg_in  = neg_q[g-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_in, quo_in[63]};
    assign diff  = trial - {1'b0, md_in};
    assign ge    = (trial >= {1'b0, md_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q[g]  <= {quo_in[62:0], ge};
      md_q[g]   <= md_in;
      neg_q[g]  <= neg_in;
      side_q[g] <= side_in;
    end
  end

  assign vld_o  = vld_q[LAST];
  assign side_o = side_q[LAST];
  assign quo_o  = quo_q[LAST];
  assign neg_o  = neg_q[LAST];

  // a beat's valid bit passes through every stage register in order and
  // leaves from the last one, once the history reaches back past reset
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, DIV_STAGES) |-> (vld_q[LAST] == $past(vld_i, DIV_STAGES)))
    else $error("divider valid out of step with its input");

  // restoring division leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST] && !side_q[LAST].inv) |-> (rem_q[LAST] < md_q[LAST]))
    else $error("divider remainder not below divisor");

endmodule

>>> sv/bptc_post.sv
// Pressure refinement after the division, rounding and saturation, five
// register stages ending in the result register. Depends on bptc_pkg.
module bptc_post import bptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  side_t       side_i,
  input  logic [63:0] quo_i,
  input  logic        neg_i,
  input  coef_t       coef_i,
  output logic        vld_o,
  output out_t        res_o
);

  logic [4:0]  vld_q, vld_d;
  side_t       side_q [4];

  logic [63:0] p_d, p_q [3];
  logic [63:0] s, sll, slh;
  logic [63:0] ss_d, ss_q, d_d, d_q [2];
  logic [63:0] c0_d, c0_q;
  logic [63:0] sum, t_d, t_q;
  logic [63:0] tq;
  out_t        res_d, res_q;

  // stage 1: restore the quotient sign
  assign p_d = neg_i ? (64'd0 - quo_i) : quo_i;

  // stage 2: square of the scaled pressure (low 64 bits) and p8 term
  always_comb begin
    s    = asr64(p_q[0], 13);
    sll  = s[31:0] * s[31:0];
    slh  = s[31:0] * s[63:32];
    ss_d = sll + {slh[30:0], 33'd0};
    d_d  = mul64x17(p_q[0], sx17(coef_i.p8));
  end

  // stage 3: p9 term
  assign c0_d = mul64x17(ss_q, sx17(coef_i.p9));

  // stage 4: sum the corrections and add the p7 offset
  always_comb begin
    sum = p_q[2] + asr64(c0_q, 25) + asr64(d_q[1], 19);
    t_d = asr64(sum, 8) + {{44{coef_i.p7[15]}}, coef_i.p7, 4'd0};
  end

  // stage 5: divide by 256 toward zero and saturate
  always_comb begin
    tq                  = t_q[63] ? asr64(t_q + 64'd255, 8) : asr64(t_q, 8);
    res_d.temp_centi    = side_q[3].tc;
    res_d.press_invalid = side_q[3].inv;
    priority if (side_q[3].inv || tq[63]) begin
      res_d.press_pa = '0;
    end else if (tq > PRESS_MAX) begin
      res_d.press_pa = '1;
    end else begin
      res_d.press_pa = tq[23:0];
    end
  end

  // valid bits
  assign vld_d = {vld_q[3:0], vld_i};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    p_q[0]    <= p_d;
    p_q[1]    <= p_q[0];
    p_q[2]    <= p_q[1];
    ss_q      <= ss_d;
    d_q[0]    <= d_d;
    d_q[1]    <= d_q[0];
    c0_q      <= c0_d;
    t_q       <= t_d;
    res_q     <= res_d;
    side_q[0] <= side_i;
    for (int i = 1; i < 4; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign vld_o = vld_q[4];
  assign res_o = res_q;

endmodule
